// ===== rtl/rlpc_pkg.sv =====
package rlpc_pkg;

  // opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SWAP   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_RENDER = 2'd3;

  // config register indexes
  localparam logic [2:0] CFG_ROAD_MODE = 3'd0;
  localparam logic [2:0] CFG_ROAD_PAL  = 3'd1;
  localparam logic [2:0] CFG_BG_PAL    = 3'd2;
  localparam logic [2:0] CFG_SKY_PAL   = 3'd3;
  localparam logic [2:0] CFG_SCROLL    = 3'd4;

  localparam logic [11:0] ROAD_PAL_RST = 12'h400;
  localparam logic [11:0] BG_PAL_RST   = 12'h420;
  localparam logic [11:0] SKY_PAL_RST  = 12'h780;

  // road RAM: two banks of 2048 words
  localparam int RAM_AW    = 11;
  localparam int RAM_WORDS = 2048;
  localparam int BANK_AW   = RAM_AW + 1;

  localparam logic [RAM_AW-1:0] ROAD1_LINE_BASE = 11'h100;
  localparam logic [RAM_AW-1:0] HPOS0_BASE      = 11'h200;
  localparam logic [RAM_AW-1:0] HPOS1_BASE      = 11'h400;
  localparam logic [RAM_AW-1:0] COLOR_BASE      = 11'h600;

  localparam logic [11:0] HPOS_BIAS  = 12'h5f8;
  localparam logic [11:0] HPOS_LIMIT = 12'h200;
  localparam int LOW_PRIO_BIT    = 11;
  localparam int NO_BG_SPLIT_BIT = 9;

  // pattern lines: 64 columns of eight 3-bit pixels
  localparam int COL_W     = 6;
  localparam int PIX_W     = 3;
  localparam int PWORD_W   = 8 * PIX_W;
  localparam logic [COL_W-1:0] STRIPE_COL = 6'd31;
  localparam logic [PIX_W-1:0] PIX_BG     = 3'd3;
  localparam logic [PIX_W-1:0] PIX_STRIPE = 3'd7;

  // bit p1 of entry p0 set: road1 wins
  localparam logic [7:0] PRIO_MAP_A [8] = '{8'h80, 8'h81, 8'h81, 8'h87,
                                            8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] PRIO_MAP_B [8] = '{8'h81, 8'h81, 8'h81, 8'h8f,
                                            8'h00, 8'h00, 8'h00, 8'h80};

  typedef struct packed {
    logic [2:0]  road_mode;
    logic [11:0] road_pal;
    logic [11:0] bg_pal;
    logic [11:0] sky_pal;
  } shade_cfg_t;

  typedef struct packed {
    logic             on_screen;
    logic [15:0]      data0;
    logic [15:0]      data1;
    logic [15:0]      cw0;
    logic [15:0]      cw1;
    logic [PIX_W-1:0] pix0;
    logic [PIX_W-1:0] pix1;
  } shade_in_t;

endpackage

// ===== rtl/rlpc_in_if.sv =====
interface rlpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [10:0] word_address;
  logic [15:0] word_data;
  logic [8:0]  pattern_line;
  logic [5:0]  pattern_byte_column;
  logic [7:0]  pattern_plane0;
  logic [7:0]  pattern_plane1;
  logic [7:0]  screen_y;
  logic [8:0]  screen_x;

  modport source(output valid, opcode, word_address, word_data, pattern_line,
                 pattern_byte_column, pattern_plane0, pattern_plane1, screen_y,
                 screen_x, input ready);
  modport sink(input valid, opcode, word_address, word_data, pattern_line,
               pattern_byte_column, pattern_plane0, pattern_plane1, screen_y,
               screen_x, output ready);
endinterface

// ===== rtl/rlpc_out_if.sv =====
interface rlpc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_color;
  logic        pixel_drawn;

  modport source(output valid, pixel_color, pixel_drawn, input ready);
  modport sink(input valid, pixel_color, pixel_drawn, output ready);
endinterface

// ===== rtl/rlpc_road_ram.sv =====
module rlpc_road_ram
  import rlpc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  logic [15:0]        wdata,
  input  logic [BANK_AW-1:0] raddr_a,
  input  logic [BANK_AW-1:0] raddr_b,
  output logic [15:0]        rdata_a,
  output logic [15:0]        rdata_b
);

  logic [15:0] mem [2*RAM_WORDS];
  logic [15:0] rdata_a_r;
  logic [15:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/rlpc_pattern_mem.sv =====
module rlpc_pattern_mem
  import rlpc_pkg::*;
#(
  parameter int LINES = 512,
  parameter int LB    = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic                we,
  input  logic [LB-1:0]       wline,
  input  logic [COL_W-1:0]    wcol,
  input  logic [7:0]          plane0,
  input  logic [7:0]          plane1,
  input  logic [LB+COL_W-1:0] raddr_a,
  input  logic [LB+COL_W-1:0] raddr_b,
  output logic [PWORD_W-1:0]  rdata_a,
  output logic [PWORD_W-1:0]  rdata_b
);

  logic [PWORD_W-1:0] mem [LINES*64];
  logic [PWORD_W-1:0] rdata_a_r;
  logic [PWORD_W-1:0] rdata_b_r;
  logic [PWORD_W-1:0] wword;

  // pixel i (leftmost first) sits at bits [3i +: 3]; stripe marking on column 31
  always_comb begin
    logic [PIX_W-1:0] p;
    wword = '0;
    for (int i = 0; i < 8; i++) begin
      p = {1'b0, plane1[7-i], plane0[7-i]};
      if (wcol == STRIPE_COL && p == PIX_BG) begin
        p = PIX_STRIPE;
      end
      wword[PIX_W*i +: PIX_W] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wline, wcol}] <= wword;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/rlpc_shade.sv =====
module rlpc_shade
  import rlpc_pkg::*;
(
  input  shade_cfg_t  cfg,
  input  shade_in_t   si,
  output logic [11:0] color,
  output logic        drawn
);

  function automatic logic [11:0] road_color(input logic r, input logic [PIX_W-1:0] pix,
                                             input logic [15:0] data,
                                             input logic [15:0] cw,
                                             input shade_cfg_t c);
    logic [11:0] off;
    logic [3:0]  nib;
    logic [11:0] base0;
    logic [11:0] res;
    off   = r ? 12'h008 : 12'h000;
    nib   = r ? cw[7:4] : cw[3:0];
    base0 = c.road_pal ^ off ^ {11'd0, nib[0]};
    case (pix)
      3'd0: res = base0;
      3'd1: res = c.road_pal ^ (off | 12'h002) ^ {11'd0, nib[1]};
      3'd2: res = c.road_pal ^ (off | 12'h004) ^ {11'd0, nib[2]};
      3'd3: begin
        if (data[NO_BG_SPLIT_BIT]) begin
          res = base0;
        end else begin
          res = c.bg_pal ^ (r ? 12'h010 : 12'h000) ^ {8'd0, cw[11:8]};
        end
      end
      default: res = c.road_pal ^ (off | 12'h006) ^ {11'd0, nib[3]};
    endcase
    return res;
  endfunction

  logic [1:0]  mode;
  logic        low0;
  logic        low1;
  logic        sky;
  logic [6:0]  sky_raw;
  logic [11:0] col0;
  logic [11:0] col1;
  logic        win1;
  logic        early;

  assign mode = cfg.road_mode[1:0];
  assign low0 = si.data0[LOW_PRIO_BIT];
  assign low1 = si.data1[LOW_PRIO_BIT];
  assign col0 = road_color(1'b0, si.pix0, si.data0, si.cw0, cfg);
  assign col1 = road_color(1'b1, si.pix1, si.data1, si.cw1, cfg);

  always_comb begin
    sky     = 1'b0;
    sky_raw = '0;
    win1    = 1'b0;
    case (mode)
      2'd0: begin
        sky     = low0;
        sky_raw = si.data0[6:0];
      end
      2'd1: begin
        sky     = low0 | low1;
        sky_raw = low0 ? si.data0[6:0] : si.data1[6:0];
        win1    = PRIO_MAP_A[si.pix0][si.pix1];
      end
      2'd2: begin
        sky     = low0 | low1;
        sky_raw = low1 ? si.data1[6:0] : si.data0[6:0];
        win1    = PRIO_MAP_B[si.pix0][si.pix1];
      end
      default: begin
        sky     = low1;
        sky_raw = si.data1[6:0];
        win1    = 1'b1;
      end
    endcase
  end

  assign early = (low0 & low1) | (mode == 2'd0 & low0) | (mode == 2'd3 & low1);

  always_comb begin
    if (!si.on_screen) begin
      drawn = 1'b0;
      color = '0;
    end else if (early) begin
      drawn = sky;
      color = sky ? ({5'd0, sky_raw} | cfg.sky_pal) : 12'd0;
    end else begin
      drawn = 1'b1;
      color = win1 ? col1 : col0;
    end
  end

endmodule

// ===== rtl/road_layer_pixel_compositor_top.sv =====
// Two-road scanline layer. Every transfer on in_ch is one command: write a road
// RAM word into the CPU bank, swap the CPU and display banks, load eight pattern
// pixels of one line, or render one pixel. Only render gives a result on out_ch.
// The block takes one command per cycle through a four-stage pipeline (line word
// read, scroll/colour word read, pattern fetch, shading) and a two-entry output
// buffer, so a stalled output holds the pipeline only once both entries are full.
// Commands act in transfer order: a render sees every earlier write, swap and
// load. After reset each road RAM copy is cleared, one word per cycle, over all
// 4096 words with in_ch.ready low; config writes are taken at any time but must
// be issued only while no command is in flight.
// Pattern entries read before they were loaded give an undefined colour.
module road_layer_pixel_compositor_top
  import rlpc_pkg::*;
#(
  parameter int PATTERN_LINES = 512,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 224
) (
  input  logic         clk,
  input  logic         rst_n,
  rlpc_in_if.sink      in_ch,
  rlpc_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  localparam int LB = (PATTERN_LINES > 1) ? $clog2(PATTERN_LINES) : 1;
  localparam int PA = LB + COL_W;

  // ---- config registers ----
  logic [2:0]  road_mode_r;
  logic [11:0] road_pal_r;
  logic [11:0] bg_pal_r;
  logic [11:0] sky_pal_r;
  logic [11:0] scroll_adj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      road_mode_r  <= '0;
      road_pal_r   <= ROAD_PAL_RST;
      bg_pal_r     <= BG_PAL_RST;
      sky_pal_r    <= SKY_PAL_RST;
      scroll_adj_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROAD_MODE: road_mode_r  <= cfg_data[2:0];
        CFG_ROAD_PAL:  road_pal_r   <= cfg_data;
        CFG_BG_PAL:    bg_pal_r     <= cfg_data;
        CFG_SKY_PAL:   sky_pal_r    <= cfg_data;
        CFG_SCROLL:    scroll_adj_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- flow control ----
  // The whole pipeline moves together; it stops only while the skid entry
  // holds a result, so ready has no path from out_ch.ready.
  logic adv;
  logic skid_valid_r;
  logic clr_busy_r;
  logic [BANK_AW-1:0] clr_addr_r;
  logic accept;

  assign adv         = !skid_valid_r;
  assign in_ch.ready = adv && !clr_busy_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // reset sweep over both banks of every RAM copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {BANK_AW{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---- stage A: captured command; line word reads, bank swap ----
  logic        a_valid_r;
  logic [1:0]  a_op_r;
  logic [10:0] a_addr_r;
  logic [15:0] a_data_r;
  logic [8:0]  a_line_r;
  logic [5:0]  a_col_r;
  logic [7:0]  a_pl0_r;
  logic [7:0]  a_pl1_r;
  logic [7:0]  a_y_r;
  logic [8:0]  a_x_r;
  logic        bank_r;
  logic        a_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r   <= in_ch.opcode;
      a_addr_r <= in_ch.word_address;
      a_data_r <= in_ch.word_data;
      a_line_r <= in_ch.pattern_line;
      a_col_r  <= in_ch.pattern_byte_column;
      a_pl0_r  <= in_ch.pattern_plane0;
      a_pl1_r  <= in_ch.pattern_plane1;
      a_y_r    <= in_ch.screen_y;
      a_x_r    <= in_ch.screen_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (adv && a_valid_r && a_op_r == OP_SWAP) begin
      bank_r <= ~bank_r;
    end
  end

  assign a_on = ({1'b0, a_x_r} < 10'(SCREEN_WIDTH)) && ({1'b0, a_y_r} < 9'(SCREEN_HEIGHT));

  // copy A serves the per-line words; written here so reads stay in order
  logic        ram_a_we;
  logic [BANK_AW-1:0] ram_a_waddr;
  logic [15:0] ram_a_wdata;
  logic [15:0] line_word0;
  logic [15:0] line_word1;

  assign ram_a_we    = clr_busy_r || (adv && a_valid_r && a_op_r == OP_WRITE);
  assign ram_a_waddr = clr_busy_r ? clr_addr_r : {~bank_r, a_addr_r};
  assign ram_a_wdata = clr_busy_r ? 16'd0 : a_data_r;

  rlpc_road_ram u_ram_line (
    .clk     (clk),
    .en      (adv),
    .we      (ram_a_we),
    .waddr   (ram_a_waddr),
    .wdata   (ram_a_wdata),
    .raddr_a ({bank_r, 3'd0, a_y_r}),
    .raddr_b ({bank_r, ROAD1_LINE_BASE + {3'd0, a_y_r}}),
    .rdata_a (line_word0),
    .rdata_b (line_word1)
  );

  // ---- stage B: scroll and colour word reads, line wrap ----
  logic        b_valid_r;
  logic [1:0]  b_op_r;
  logic        b_bank_r;
  logic [10:0] b_addr_r;
  logic [15:0] b_data_r;
  logic [8:0]  b_line_r;
  logic [5:0]  b_col_r;
  logic [7:0]  b_pl0_r;
  logic [7:0]  b_pl1_r;
  logic [7:0]  b_y_r;
  logic [8:0]  b_x_r;
  logic        b_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r   <= a_op_r;
      b_bank_r <= bank_r;
      b_addr_r <= a_addr_r;
      b_data_r <= a_data_r;
      b_line_r <= a_line_r;
      b_col_r  <= a_col_r;
      b_pl0_r  <= a_pl0_r;
      b_pl1_r  <= a_pl1_r;
      b_y_r    <= a_y_r;
      b_x_r    <= a_x_r;
      b_on_r   <= a_on;
    end
  end

  logic [8:0]  idx0;
  logic [8:0]  idx1;
  logic        ram_hc_we;
  logic [BANK_AW-1:0] ram_hc_waddr;
  logic [15:0] ram_hc_wdata;
  logic [15:0] hpos_word0;
  logic [15:0] color_word0;
  logic [15:0] hpos_word1;
  logic [15:0] color_word1;

  assign idx0 = road_mode_r[2] ? {1'b0, b_y_r} : line_word0[8:0];
  assign idx1 = road_mode_r[2] ? {1'b1, b_y_r} : line_word1[8:0];

  assign ram_hc_we    = clr_busy_r || (adv && b_valid_r && b_op_r == OP_WRITE);
  assign ram_hc_waddr = clr_busy_r ? clr_addr_r : {~b_bank_r, b_addr_r};
  assign ram_hc_wdata = clr_busy_r ? 16'd0 : b_data_r;

  rlpc_road_ram u_ram_road0 (
    .clk     (clk),
    .en      (adv),
    .we      (ram_hc_we),
    .waddr   (ram_hc_waddr),
    .wdata   (ram_hc_wdata),
    .raddr_a ({b_bank_r, HPOS0_BASE + {2'd0, idx0}}),
    .raddr_b ({b_bank_r, COLOR_BASE + {2'd0, idx0}}),
    .rdata_a (hpos_word0),
    .rdata_b (color_word0)
  );

  rlpc_road_ram u_ram_road1 (
    .clk     (clk),
    .en      (adv),
    .we      (ram_hc_we),
    .waddr   (ram_hc_waddr),
    .wdata   (ram_hc_wdata),
    .raddr_a ({b_bank_r, HPOS1_BASE + {2'd0, idx1}}),
    .raddr_b ({b_bank_r, COLOR_BASE + {2'd0, idx1}}),
    .rdata_a (hpos_word1),
    .rdata_b (color_word1)
  );

  // pattern line modulo PATTERN_LINES, as elaboration-time tables
  logic [LB-1:0] wrap0_tbl [256];
  logic [LB-1:0] wrap1_tbl [256];

  for (genvar k = 0; k < 256; k++) begin : g_wrap
    assign wrap0_tbl[k] = LB'(k % PATTERN_LINES);
    assign wrap1_tbl[k] = LB'((k + 256) % PATTERN_LINES);
  end

  // ---- stage C: scroll add, pattern fetch, pattern load ----
  logic          c_valid_r;
  logic [1:0]    c_op_r;
  logic [8:0]    c_line_r;
  logic [5:0]    c_col_r;
  logic [7:0]    c_pl0_r;
  logic [7:0]    c_pl1_r;
  logic [8:0]    c_x_r;
  logic          c_on_r;
  logic [15:0]   c_d0_r;
  logic [15:0]   c_d1_r;
  logic [LB-1:0] c_pline0_r;
  logic [LB-1:0] c_pline1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op_r     <= b_op_r;
      c_line_r   <= b_line_r;
      c_col_r    <= b_col_r;
      c_pl0_r    <= b_pl0_r;
      c_pl1_r    <= b_pl1_r;
      c_x_r      <= b_x_r;
      c_on_r     <= b_on_r;
      c_d0_r     <= line_word0;
      c_d1_r     <= line_word1;
      c_pline0_r <= wrap0_tbl[line_word0[8:1]];
      c_pline1_r <= wrap1_tbl[line_word1[8:1]];
    end
  end

  logic [11:0]        hpos_bias;
  logic [11:0]        hpos0;
  logic [11:0]        hpos1;
  logic               pat_we;
  logic [PWORD_W-1:0] pat_word0;
  logic [PWORD_W-1:0] pat_word1;

  assign hpos_bias = HPOS_BIAS + scroll_adj_r;
  assign hpos0     = hpos_word0[11:0] - hpos_bias + {3'd0, c_x_r};
  assign hpos1     = hpos_word1[11:0] - hpos_bias + {3'd0, c_x_r};

  // loads beyond the last pattern line are dropped
  assign pat_we = adv && c_valid_r && c_op_r == OP_LOAD
               && ({1'b0, c_line_r} < 10'(PATTERN_LINES));

  rlpc_pattern_mem #(
    .LINES (PATTERN_LINES),
    .LB    (LB)
  ) u_pattern (
    .clk     (clk),
    .en      (adv),
    .we      (pat_we),
    .wline   (c_line_r[LB-1:0]),
    .wcol    (c_col_r),
    .plane0  (c_pl0_r),
    .plane1  (c_pl1_r),
    .raddr_a ({c_pline0_r, hpos0[8:3]}),
    .raddr_b ({c_pline1_r, hpos1[8:3]}),
    .rdata_a (pat_word0),
    .rdata_b (pat_word1)
  );

  // ---- stage D: pixel select and shading ----
  logic        d_res_r;
  logic        d_on_r;
  logic [15:0] d_d0_r;
  logic [15:0] d_d1_r;
  logic [15:0] d_c0_r;
  logic [15:0] d_c1_r;
  logic        d_off0_r;
  logic        d_off1_r;
  logic [2:0]  d_sel0_r;
  logic [2:0]  d_sel1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_res_r <= 1'b0;
    end else if (adv) begin
      d_res_r <= c_valid_r && c_op_r == OP_RENDER;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_on_r   <= c_on_r;
      d_d0_r   <= c_d0_r;
      d_d1_r   <= c_d1_r;
      d_c0_r   <= color_word0;
      d_c1_r   <= color_word1;
      d_off0_r <= hpos0 >= HPOS_LIMIT;
      d_off1_r <= hpos1 >= HPOS_LIMIT;
      d_sel0_r <= hpos0[2:0];
      d_sel1_r <= hpos1[2:0];
    end
  end

  shade_cfg_t  shade_cfg;
  shade_in_t   shade_in;
  logic [11:0] sh_color;
  logic        sh_drawn;

  assign shade_cfg.road_mode = road_mode_r;
  assign shade_cfg.road_pal  = road_pal_r;
  assign shade_cfg.bg_pal    = bg_pal_r;
  assign shade_cfg.sky_pal   = sky_pal_r;

  // low priority line or scrolled off the pattern: background pixel
  assign shade_in.on_screen = d_on_r;
  assign shade_in.data0     = d_d0_r;
  assign shade_in.data1     = d_d1_r;
  assign shade_in.cw0       = d_c0_r;
  assign shade_in.cw1       = d_c1_r;
  assign shade_in.pix0 = (d_d0_r[LOW_PRIO_BIT] || d_off0_r) ? PIX_BG
                       : pat_word0[PIX_W*d_sel0_r +: PIX_W];
  assign shade_in.pix1 = (d_d1_r[LOW_PRIO_BIT] || d_off1_r) ? PIX_BG
                       : pat_word1[PIX_W*d_sel1_r +: PIX_W];

  rlpc_shade u_shade (
    .cfg   (shade_cfg),
    .si    (shade_in),
    .color (sh_color),
    .drawn (sh_drawn)
  );

  // ---- output register plus skid entry ----
  logic        out_valid_r;
  logic [11:0] out_color_r;
  logic        out_drawn_r;
  logic [11:0] skid_color_r;
  logic        skid_drawn_r;
  logic        push;
  logic        pop;

  assign push = adv && d_res_r;
  assign pop  = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_color_r <= skid_color_r;
        out_drawn_r <= skid_drawn_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_color_r <= sh_color;
        skid_drawn_r <= sh_drawn;
      end else begin
        out_color_r <= sh_color;
        out_drawn_r <= sh_drawn;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.pixel_drawn = out_drawn_r;

  // ---- checks ----
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid entry filled without an output stall");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !a_valid_r && !b_valid_r && !c_valid_r)
    else $error("command in pipeline during RAM clear");

  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(bank_r) |-> $past(adv && a_valid_r && a_op_r == OP_SWAP))
    else $error("display bank changed without a swap command");

endmodule
